@@ rtl/assert_macros.svh @@
// assertion macros used by cell_pair_contact_force
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_IMPLIES_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ccf_pkg.sv @@
// types, register indexes, divider sizes and exp tables for the contact force block
// no dependencies
package ccf_pkg;

  typedef struct packed {
    logic [23:0]        radius_a;
    logic [23:0]        radius_b;
    logic               type_a;
    logic               type_b;
    logic [23:0]        distance;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } out_t;

  localparam logic [2:0] REG_RIG0  = 3'd0;
  localparam logic [2:0] REG_RIG1  = 3'd1;
  localparam logic [2:0] REG_ADH00 = 3'd2;
  localparam logic [2:0] REG_ADH01 = 3'd3;
  localparam logic [2:0] REG_ADH10 = 3'd4;
  localparam logic [2:0] REG_ADH11 = 3'd5;
  localparam logic [2:0] REG_SCALE = 3'd6;

  localparam int DIV_NUM_W  = 49;
  localparam int DIV_DEN_W  = 25;
  localparam int DIV_Q_W    = 24;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;

  // fields carried alongside the first divider
  typedef struct packed {
    logic               zero;
    logic               over;
    logic               sat;
    logic [32:0]        rep;
    logic [31:0]        am;
    logic [23:0]        scale;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } side1_t;

  // fields carried alongside the second divider
  typedef struct packed {
    logic               zero;
    logic               over;
    logic               big;
    logic [32:0]        rep;
    logic [31:0]        am;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } side2_t;

  // exp(-n), q16
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-j/16), q16
  function automatic logic [16:0] exp_frac(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd61565;
      5'd2:    v = 17'd57835;
      5'd3:    v = 17'd54331;
      5'd4:    v = 17'd51039;
      5'd5:    v = 17'd47947;
      5'd6:    v = 17'd45042;
      5'd7:    v = 17'd42313;
      5'd8:    v = 17'd39750;
      5'd9:    v = 17'd37341;
      5'd10:   v = 17'd35079;
      5'd11:   v = 17'd32954;
      5'd12:   v = 17'd30957;
      5'd13:   v = 17'd29081;
      5'd14:   v = 17'd27319;
      5'd15:   v = 17'd25664;
      default: v = 17'd24109;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ccf_div.sv @@
// pipelined restoring divider, DIV_STEP quotient bits per stage, with sideband
// depends on ccf_pkg; requires num < den * 2^DIV_Q_W
module ccf_div #(
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [ccf_pkg::DIV_NUM_W-1:0] in_num,
  input  logic [ccf_pkg::DIV_DEN_W-1:0] in_den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_vld,
  output logic [ccf_pkg::DIV_Q_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]             out_side
);
  import ccf_pkg::*;

  localparam int DW = DIV_DEN_W;
  localparam int QW = DIV_Q_W;
  localparam int NS = DIV_STAGES;

  logic [DW-1:0]     rem_r  [NS];
  logic [QW-1:0]     low_r  [NS];
  logic [QW-1:0]     quo_r  [NS];
  logic [DW-1:0]     den_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic              vld_r  [NS];

  logic [DW-1:0]     rem_nxt [NS];
  logic [QW-1:0]     low_nxt [NS];
  logic [QW-1:0]     quo_nxt [NS];
  logic [DW-1:0]     p_rem   [NS];
  logic [QW-1:0]     p_low   [NS];
  logic [QW-1:0]     p_quo   [NS];
  logic [DW-1:0]     p_den   [NS];
  logic [SIDE_W-1:0] p_side  [NS];
  logic              p_vld   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    if (k == 0) begin : g_first
      assign p_rem[k]  = in_num[DIV_NUM_W-1:QW];
      assign p_low[k]  = in_num[QW-1:0];
      assign p_quo[k]  = '0;
      assign p_den[k]  = in_den;
      assign p_side[k] = in_side;
      assign p_vld[k]  = in_vld;
    end else begin : g_rest
      assign p_rem[k]  = rem_r[k-1];
      assign p_low[k]  = low_r[k-1];
      assign p_quo[k]  = quo_r[k-1];
      assign p_den[k]  = den_r[k-1];
      assign p_side[k] = side_r[k-1];
      assign p_vld[k]  = vld_r[k-1];
    end

    always_comb begin
      logic [DW-1:0] rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      rem = p_rem[k];
      low = p_low[k];
      quo = p_quo[k];
      for (int i = 0; i < DIV_STEP; i++) begin
        trial = {rem, low[QW-1]};
        low   = {low[QW-2:0], 1'b0};
        diff  = trial - {1'b0, p_den[k]};
        if (trial >= {1'b0, p_den[k]}) begin
          rem = diff[DW-1:0];
          quo = {quo[QW-2:0], 1'b1};
        end else begin
          rem = trial[DW-1:0];
          quo = {quo[QW-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem;
      low_nxt[k] = low;
      quo_nxt[k] = quo;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld[k];
      end
      rem_r[k]  <= rem_nxt[k];
      low_r[k]  <= low_nxt[k];
      quo_r[k]  <= quo_nxt[k];
      den_r[k]  <= p_den[k];
      side_r[k] <= p_side[k];
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_quo  = quo_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

@@ rtl/ccf_lane.sv @@
// one force component: magnitude times direction, then saturation to q16.16
// depends on ccf_pkg
module ccf_lane (
  input  logic               clk,
  input  logic [32:0]        mag,
  input  logic               mag_neg,
  input  logic signed [15:0] dir,
  output logic signed [31:0] force_out
);
  import ccf_pkg::*;

  logic [34:0]        prod_r;
  logic [34:0]        prod_nxt;
  logic               neg_r;
  logic               neg_nxt;
  logic signed [31:0] force_r;
  logic signed [31:0] force_nxt;

  always_comb begin
    logic [15:0] dabs;
    logic [48:0] full;
    dabs    = dir[15] ? 16'(-dir) : 16'(dir);
    neg_nxt = mag_neg ^ dir[15];
    full    = 49'(mag) * 49'(dabs);
    prod_nxt = full[48:14];
  end

  always_comb begin
    logic [34:0] neg_v;
    neg_v = 35'(0) - prod_r;
    if (prod_r == '0) begin
      force_nxt = '0;
    end else if (neg_r) begin
      if (prod_r >= 35'h0_8000_0000) force_nxt = 32'sh8000_0000;
      else force_nxt = neg_v[31:0];
    end else begin
      if (prod_r > 35'h0_7FFF_FFFF) force_nxt = 32'sh7FFF_FFFF;
      else force_nxt = prod_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    force_r <= force_nxt;
  end

  assign force_out = force_r;

endmodule

@@ rtl/cell_pair_contact_force.sv @@
// cell pair contact force: soft sphere repulsion with gaussian adhesion
// depends on ccf_pkg, ccf_div, ccf_lane and assert_macros.svh
//
//  channel  ports                          handshake
//  in       start, busy, in_data           taken when start && !busy
//  out      out_valid, out_data            one-cycle strobe, no back pressure
//  cfg      cfg_we, cfg_idx, cfg_data      written when cfg_we
//
// one pair per cycle; a request reaches the strobe through the two 6-stage
// dividers (4 quotient bits per stage) plus the input, multiply, exp table
// and saturation stages
// busy is always low; nothing ever stalls, every stage advances each cycle
// reset clears the valid bits and loads the register defaults
`include "assert_macros.svh"

module cell_pair_contact_force #(
  parameter int DIMS = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ccf_pkg::in_t  in_data,
  output logic          out_valid,
  output ccf_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [23:0]   cfg_data
);
  import ccf_pkg::*;

  localparam int LAT = 2 * DIV_STAGES + 8;

  // configuration registers
  logic [23:0] rig0_r, rig1_r, adh00_r, adh01_r, adh10_r, adh11_r, scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rig0_r  <= 24'd65536;
      rig1_r  <= 24'd65536;
      adh00_r <= '0;
      adh01_r <= '0;
      adh10_r <= '0;
      adh11_r <= '0;
      scale_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RIG0:  rig0_r  <= cfg_data;
        REG_RIG1:  rig1_r  <= cfg_data;
        REG_ADH00: adh00_r <= cfg_data;
        REG_ADH01: adh01_r <= cfg_data;
        REG_ADH10: adh10_r <= cfg_data;
        REG_ADH11: adh11_r <= cfg_data;
        REG_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: radius sum and per-type parameter selection
  logic        v1_r;
  logic [24:0] rsum_r, rsum_nxt;
  logic [23:0] dist_r;
  logic [24:0] rs_r, rs_nxt;
  logic [23:0] a_r, a_nxt;
  logic [23:0] sc_r, sc_nxt;
  logic signed [15:0] dx1_r, dy1_r, dz1_r;

  always_comb begin
    logic [23:0] rig_a;
    logic [23:0] rig_b;
    rig_a    = in_data.type_a ? rig1_r : rig0_r;
    rig_b    = in_data.type_b ? rig1_r : rig0_r;
    rsum_nxt = 25'(in_data.radius_a) + 25'(in_data.radius_b);
    rs_nxt   = 25'(rig_a) + 25'(rig_b);
    case ({in_data.type_a, in_data.type_b})
      2'b00:   a_nxt = adh00_r;
      2'b01:   a_nxt = adh01_r;
      2'b10:   a_nxt = adh10_r;
      default: a_nxt = adh11_r;
    endcase
    sc_nxt = (scale_r == '0) ? 24'd1 : scale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    rsum_r <= rsum_nxt;
    dist_r <= in_data.distance;
    rs_r   <= rs_nxt;
    a_r    <= a_nxt;
    sc_r   <= sc_nxt;
    dx1_r  <= in_data.dir_x;
    dy1_r  <= in_data.dir_y;
    dz1_r  <= in_data.dir_z;
  end

  // stage 2 logic feeds the first divider: overlap, repulsion, d / R setup
  side1_t                 side1;
  logic [DIV_NUM_W-1:0]   num1;
  logic [DIV_DEN_W-1:0]   den1;

  always_comb begin
    logic        zero;
    logic        over;
    logic        adh;
    logic [24:0] d_full;
    logic [23:0] d;
    logic [24:0] ovl;
    logic [49:0] rep_p;
    logic [47:0] am_p;
    logic [32:0] r_sh;
    zero   = (rsum_r == '0);
    over   = (25'(dist_r) <= rsum_r);
    adh    = !zero && !over;
    d_full = 25'(dist_r) - rsum_r;
    d      = d_full[23:0];
    ovl    = rsum_r - 25'(dist_r);
    rep_p  = 50'(rs_r) * 50'(ovl);
    am_p   = 48'(a_r) * 48'(d);
    r_sh   = {rsum_r, 8'h00};
    side1.zero  = zero;
    side1.over  = over;
    // quotient at or past 2^24 saturates
    side1.sat   = 33'(d) >= r_sh;
    side1.rep   = rep_p[49:17];
    side1.am    = am_p[47:16];
    side1.scale = sc_r;
    side1.dx    = dx1_r;
    side1.dy    = dy1_r;
    side1.dz    = dz1_r;
    num1 = (adh && !side1.sat) ? DIV_NUM_W'({d, 16'h0000}) : '0;
    den1 = adh ? rsum_r : DIV_DEN_W'(1);
  end

  logic                 q1_vld;
  logic [DIV_Q_W-1:0]   q1;
  logic [$bits(side1_t)-1:0] q1_side_bits;
  side1_t               q1_side;

  ccf_div #(.SIDE_W($bits(side1_t))) u_div_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1_r),
    .in_num   (num1),
    .in_den   (den1),
    .in_side  (side1),
    .out_vld  (q1_vld),
    .out_quo  (q1),
    .out_side (q1_side_bits)
  );

  assign q1_side = side1_t'(q1_side_bits);

  // stage: u squared
  logic        v3_r;
  logic [48:0] uu_r, uu_nxt;
  side1_t      s3_r;

  always_comb begin
    logic [24:0] u;
    logic [49:0] p;
    u      = q1_side.sat ? 25'h100_0000 : {1'b0, q1};
    p      = 50'(u) * 50'(u);
    uu_nxt = p[48:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= q1_vld;
    end
    uu_r <= uu_nxt;
    s3_r <= q1_side;
  end

  // stage: exp(-t) underflows once t reaches 12.0
  logic                 v4_r;
  logic [DIV_NUM_W-1:0] num2_r, num2_nxt;
  logic [23:0]          den2_r;
  side2_t               s4_r, s4_nxt;

  always_comb begin
    logic [43:0] lim;
    lim = {1'b0, s3_r.scale, 19'h00000} + {2'b00, s3_r.scale, 18'h00000};
    // lim is scale * 12 << 16
    s4_nxt.zero = s3_r.zero;
    s4_nxt.over = s3_r.over;
    s4_nxt.big  = uu_r >= 49'(lim);
    s4_nxt.rep  = s3_r.rep;
    s4_nxt.am   = s3_r.am;
    s4_nxt.dx   = s3_r.dx;
    s4_nxt.dy   = s3_r.dy;
    s4_nxt.dz   = s3_r.dz;
    num2_nxt    = s4_nxt.big ? '0 : uu_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    num2_r <= num2_nxt;
    den2_r <= s3_r.scale;
    s4_r   <= s4_nxt;
  end

  logic                 t_vld;
  logic [DIV_Q_W-1:0]   t_q;
  logic [$bits(side2_t)-1:0] t_side_bits;
  side2_t               t_side;

  ccf_div #(.SIDE_W($bits(side2_t))) u_div_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_num   (num2_r),
    .in_den   (DIV_DEN_W'(den2_r)),
    .in_side  (s4_r),
    .out_vld  (t_vld),
    .out_quo  (t_q),
    .out_side (t_side_bits)
  );

  assign t_side = side2_t'(t_side_bits);

  // stage: fractional exp with interpolation
  logic        v5_r;
  logic [16:0] e2_r, e2_nxt;
  logic [3:0]  n_r;
  side2_t      s5_r;

  always_comb begin
    logic [4:0]  j;
    logic [11:0] r;
    logic [16:0] e_hi;
    logic [16:0] e_lo;
    logic [16:0] diff;
    logic [29:0] step;
    j      = {1'b0, t_q[15:12]};
    r      = t_q[11:0];
    e_hi   = exp_frac(j);
    e_lo   = exp_frac(j + 5'd1);
    diff   = e_hi - e_lo;
    step   = 30'(diff) * 30'(r) + 30'd2048;
    e2_nxt = e_hi - 17'(step[29:12]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= t_vld;
    end
    e2_r <= e2_nxt;
    n_r  <= t_q[19:16];
    s5_r <= t_side;
  end

  // stage: integer part of exp
  logic        v6_r;
  logic [16:0] e_r, e_nxt;
  side2_t      s6_r;

  always_comb begin
    logic [34:0] p;
    p     = 35'(exp_int(n_r)) * 35'(e2_r) + 35'd32768;
    e_nxt = s5_r.big ? '0 : p[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    e_r  <= e_nxt;
    s6_r <= s5_r;
  end

  // stage: adhesion magnitude and branch select
  logic        v7_r;
  logic [32:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic signed [15:0] dx7_r, dy7_r, dz7_r;

  always_comb begin
    logic [48:0] p;
    p = 49'(s6_r.am) * 49'(e_r);
    if (s6_r.zero) begin
      mag_nxt = '0;
    end else if (s6_r.over) begin
      mag_nxt = s6_r.rep;
    end else begin
      mag_nxt = p[48:16];
    end
    neg_nxt = !s6_r.zero && !s6_r.over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    dx7_r <= s6_r.dx;
    dy7_r <= s6_r.dy;
    dz7_r <= s6_r.dz;
  end

  // component lanes, two stages each
  logic v8_r, v9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  logic signed [31:0] fx, fy, fz;

  ccf_lane u_lane_x (
    .clk (clk), .mag (mag_r), .mag_neg (neg_r), .dir (dx7_r), .force_out (fx)
  );

  ccf_lane u_lane_y (
    .clk (clk), .mag (mag_r), .mag_neg (neg_r), .dir (dy7_r), .force_out (fy)
  );

  if (DIMS >= 3) begin : g_z
    ccf_lane u_lane_z (
      .clk (clk), .mag (mag_r), .mag_neg (neg_r), .dir (dz7_r), .force_out (fz)
    );
  end else begin : g_no_z
    logic signed [15:0] dz_unused;
    assign dz_unused = dz7_r;
    assign fz = 32'(dz_unused & 16'sd0);
  end

  assign out_valid        = v9_r;
  assign out_data.force_x = fx;
  assign out_data.force_y = fy;
  assign out_data.force_z = fz;

  `ASSERT_IMPLIES(a_latency, out_valid, $past(start, LAT))
  `ASSERT_IMPLIES(a_t_range, t_vld && !t_side.big, t_q < 24'd786432)
  `ASSERT_IMPLIES_NEXT(a_e_range, v5_r, e_r <= 17'd65536)

endmodule
